FILE: rtl/core/utf8_lenient_stream_decoder_core_assert.svh
// assertion macros for the lenient utf-8 stream decoder core
// needs nothing else; define SYNTH to drop the checks from a netlist
`ifndef UTF8_LENIENT_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_LENIENT_STREAM_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define U8D_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("u8d assertion failed");
// next-cycle implication, checked out of reset
`define U8D_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("u8d assertion failed");
`else
`define U8D_ASSERT_NOW(label, clk, rst, cond, prop)
`define U8D_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

FILE: rtl/core/u8dec_pkg.sv
// shared types, constants and helpers of the lenient utf-8 stream decoder
// used by utf8_lenient_stream_decoder_core; depends on nothing
package u8dec_pkg;

   localparam int BYTE_W      = 8;
   localparam int CP_W        = 21;
   localparam int COUNT_W     = 3;
   localparam int MAX_RESULTS = 4;
   localparam int HELD_DEPTH  = 3;
   localparam int HELD_IDX_W  = $clog2(HELD_DEPTH);
   localparam int LEFT_W      = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_W      = $clog2(MAX_RESULTS);

   // sequence lengths
   localparam logic [COUNT_W-1:0] LEN_NONE = 3'd0;
   localparam logic [COUNT_W-1:0] LEN_RAW  = 3'd1;
   localparam logic [COUNT_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
   localparam logic [COUNT_W-1:0] LEN_FOUR = 3'd4;

   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [CP_W-1:0]    cp_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      cp_type    code_point;
      count_type byte_count;
   } entry_type;

   function automatic count_type lead_width(input byte_type b);
      count_type w;
      priority if (b[7:5] == 3'b110) w = LEN_TWO;
      else if (b[7:4] == 4'b1110)    w = LEN_THREE;
      else if (b[7:3] == 5'b11110)   w = LEN_FOUR;
      else                           w = LEN_RAW;
      return w;
   endfunction

endpackage

FILE: rtl/core/utf8_lenient_stream_decoder_core.sv
// lenient utf-8 stream decoder: bytes in, code points with byte counts out
// depends on u8dec_pkg and utf8_lenient_stream_decoder_core_assert.svh
//
//   channel | ports                                          | moves
//   --------+------------------------------------------------+---------------------
//   req     | req_valid req_stall req_byte_value             | one byte per word
//   rsp     | rsp_valid rsp_stall rsp_code_point             | one character per
//           | rsp_byte_count rsp_last_of_run                 | word
//
// a byte is taken every cycle as long as each byte gives at most one word and rsp
// does not stall; a byte that gives k words (up to four) holds the result buffer until all k have left.
// a taken byte passes the input register and then the result buffer before its first
// word shows on rsp.
// reset clears the pending sequence and both buffers at once; no clearing pass.
// a stalled rsp side holds the buffered words; the input register takes one more byte.
`include "utf8_lenient_stream_decoder_core_assert.svh"

module utf8_lenient_stream_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [u8dec_pkg::BYTE_W-1:0]  req_byte_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [u8dec_pkg::CP_W-1:0]    rsp_code_point,
   output logic [u8dec_pkg::COUNT_W-1:0] rsp_byte_count,
   output logic                          rsp_last_of_run
);

   localparam logic [u8dec_pkg::LEFT_W-1:0] LEFT_W_ONE = 1;

   // input register
   logic                 in_valid_ff;
   u8dec_pkg::byte_type  in_byte_ff;

   // decode state
   u8dec_pkg::byte_type  held_ff [u8dec_pkg::HELD_DEPTH];
   logic [1:0]           cnt_ff, cnt_in;
   u8dec_pkg::count_type exp_ff, exp_in;

   // result buffer
   u8dec_pkg::entry_type           ent_ff [u8dec_pkg::MAX_RESULTS];
   u8dec_pkg::entry_type           ent_in [u8dec_pkg::MAX_RESULTS];
   logic [u8dec_pkg::LEFT_W-1:0]   left_ff, left_in;
   logic [u8dec_pkg::SLOT_W-1:0]   slot_ff;

   logic                               advance;
   logic                               rsp_take;
   logic                               open_seq, is_cont, complete, raw_out;
   logic [1:0]                         flush_n;
   u8dec_pkg::count_type               width;
   u8dec_pkg::cp_type                  joined;
   u8dec_pkg::byte_type                held_ext [u8dec_pkg::MAX_RESULTS];
   logic                               held_we;
   logic [u8dec_pkg::HELD_IDX_W-1:0]   held_idx;

   assign rsp_valid       = (left_ff != '0);
   assign rsp_take        = rsp_valid && !rsp_stall;
   // the buffer frees up when empty or when its final word leaves now
   assign advance         = in_valid_ff &&
                            ((left_ff == '0) || ((left_ff == LEFT_W_ONE) && !rsp_stall));
   assign req_stall       = in_valid_ff && !advance;
   assign rsp_code_point  = ent_ff[slot_ff].code_point;
   assign rsp_byte_count  = ent_ff[slot_ff].byte_count;
   assign rsp_last_of_run = (left_ff == LEFT_W_ONE);

   always_comb begin
      open_seq = (exp_ff >= u8dec_pkg::LEN_TWO) && (exp_ff <= u8dec_pkg::LEN_FOUR) &&
                 (cnt_ff != 2'd0) && ({1'b0, cnt_ff} < exp_ff);
      is_cont  = (in_byte_ff[7:6] == u8dec_pkg::CONT_TAG);
      complete = open_seq && is_cont && ({1'b0, cnt_ff} + 3'd1 == exp_ff);
      width    = u8dec_pkg::lead_width(in_byte_ff);
      raw_out  = (in_byte_ff != '0) && (width == u8dec_pkg::LEN_RAW);
      flush_n  = open_seq ? cnt_ff : 2'd0;

      unique case (exp_ff)
         u8dec_pkg::LEN_TWO:
            joined = {10'd0, held_ff[0][4:0], in_byte_ff[5:0]};
         u8dec_pkg::LEN_THREE:
            joined = {5'd0, held_ff[0][3:0], held_ff[1][5:0], in_byte_ff[5:0]};
         default:
            joined = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0], in_byte_ff[5:0]};
      endcase

      for (int i = 0; i < u8dec_pkg::HELD_DEPTH; i++) held_ext[i] = held_ff[i];
      held_ext[u8dec_pkg::MAX_RESULTS-1] = in_byte_ff;

      held_we  = 1'b0;
      held_idx = cnt_ff[u8dec_pkg::HELD_IDX_W-1:0];
      cnt_in   = 2'd0;
      exp_in   = u8dec_pkg::LEN_NONE;
      left_in  = '0;
      for (int i = 0; i < u8dec_pkg::MAX_RESULTS; i++) begin
         // flushed held bytes first, then the raw byte
         ent_in[i].code_point = {13'd0, (i < flush_n) ? held_ext[i] : in_byte_ff};
         ent_in[i].byte_count = u8dec_pkg::LEN_RAW;
      end

      if (open_seq && is_cont) begin
         if (complete) begin
            ent_in[0].code_point = joined;
            ent_in[0].byte_count = exp_ff;
            left_in = LEFT_W_ONE;
         end else begin
            held_we = 1'b1;
            cnt_in  = cnt_ff + 2'd1;
            exp_in  = exp_ff;
         end
      end else begin
         left_in = {1'b0, flush_n} + {2'b0, raw_out};
         if ((in_byte_ff != '0) && (width != u8dec_pkg::LEN_RAW)) begin
            held_we  = 1'b1;
            held_idx = '0;
            cnt_in   = 2'd1;
            exp_in   = width;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         exp_ff      <= u8dec_pkg::LEN_NONE;
         left_ff     <= '0;
         slot_ff     <= '0;
      end else begin
         if (!req_stall) in_valid_ff <= req_valid;
         if (advance) begin
            cnt_ff  <= cnt_in;
            exp_ff  <= exp_in;
            left_ff <= left_in;
            slot_ff <= '0;
         end else if (rsp_take) begin
            left_ff <= left_ff - LEFT_W_ONE;
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) in_byte_ff <= req_byte_value;
      if (advance) begin
         for (int i = 0; i < u8dec_pkg::MAX_RESULTS; i++) ent_ff[i] <= ent_in[i];
         if (held_we) held_ff[held_idx] <= in_byte_ff;
      end
   end

   `U8D_ASSERT_NOW(a_count_range, clock, reset, rsp_valid,
      (rsp_byte_count != 3'd0) && (rsp_byte_count <= u8dec_pkg::LEN_FOUR))
   `U8D_ASSERT_NOW(a_joined_is_last, clock, reset,
      rsp_valid && (rsp_byte_count != u8dec_pkg::LEN_RAW), rsp_last_of_run)
   `U8D_ASSERT_NOW(a_open_consistent, clock, reset, exp_ff != u8dec_pkg::LEN_NONE,
      (cnt_ff != 2'd0) && ({1'b0, cnt_ff} < exp_ff))
   `U8D_ASSERT_NOW(a_idle_empty, clock, reset, exp_ff == u8dec_pkg::LEN_NONE,
      cnt_ff == 2'd0)
   `U8D_ASSERT_NEXT(a_stalled_word_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(slot_ff))

endmodule
